FILE: rtl/range_assign_add_kth_powsum_store_defines.svh
// Assertion macros for the range value store.
// Used by the top level only; needs clk and arst_n in scope.
`ifndef RANGE_ASSIGN_ADD_KTH_POWSUM_STORE_DEFINES_SVH
`define RANGE_ASSIGN_ADD_KTH_POWSUM_STORE_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define RAKPS_ASSERT_SAME(lbl, pre, post) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (pre) |-> (post)) else $error("check failed");

// Condition holds in the cycle after the trigger.
`define RAKPS_ASSERT_NEXT(lbl, pre, post) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (pre) |=> (post)) else $error("check failed");

`endif

FILE: rtl/rakps_pkg.sv
// Shared types and constants for the range value store.
// No dependencies; imported by every module of the block.
package rakps_pkg;

	localparam int VAL_W = 63;
	localparam int POS_W = 11;
	localparam int MOD_W = 31;
	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

	// Operation codes carried in tuser
	typedef enum logic [1:0] {
		FN_ADD = 2'd0,
		FN_ASG = 2'd1,
		FN_KTH = 2'd2,
		FN_POW = 2'd3
	} func_t;

	// Start request to a modular multiplier
	typedef struct packed {
		logic             start;
		logic [MOD_W-1:0] a;
		logic [VAL_W-1:0] b;
		logic [5:0]       steps;
	} mm_req_t;

endpackage

FILE: rtl/rakps_mem.sv
// Value memory: one write port and one read port, registered read data.
// Depends on rakps_pkg for the value width.
module rakps_mem
	import rakps_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [VAL_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/rakps_modmul.sv
// Bit-serial modular multiplier: r = (a * b) mod m, one bit of b per cycle, MSB first.
// Depends on rakps_pkg for widths and the request struct. Requires a < m.
module rakps_modmul
	import rakps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mm_req_t          req,
	input  logic [MOD_W-1:0] m,
	output logic             busy,
	output logic             done,
	output logic [MOD_W-1:0] r
);

	logic [VAL_W-1:0] b_q;
	logic [MOD_W-1:0] a_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MOD_W-1:0] r_q;
	logic [MOD_W:0]   dbl;
	logic [MOD_W:0]   dbl_red;
	logic [MOD_W:0]   sum;
	logic [MOD_W:0]   sum_red;

	// One step: double, reduce, conditionally add a, reduce
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		sum     = b_q[VAL_W-1] ? dbl_red + {1'b0, a_q} : dbl_red;
		sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
	end

	// Step counter and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= {b_q[VAL_W-2:0], 1'b0};
			r_q <= sum_red[MOD_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign r    = r_q;

endmodule

FILE: rtl/range_assign_add_kth_powsum_store.sv
// Channel  | Signals                          | Word contents (low bit up)
// input    | s_axis_tvalid/tready/tdata/tuser | tdata: left_pos, right_pos, operand, modulus
//          |                                  | tuser: func
// output   | m_axis_tvalid/tready/tdata/tuser | tdata: answer; tuser: not_found
//
// One request at a time; n is the clamped range length.
// Add and assign: one read-modify-write per cycle over the n positions.
// Kth: one radix-select pass over the n positions per value bit.
// Power sum: per element, a reduction and square-and-multiply steps on the bit-serial
// modular multipliers. Reset needs no clearing pass.
// A new request is taken while a finished answer waits in the output register.
module range_assign_add_kth_powsum_store
	import rakps_pkg::*;
#(
	parameter int POSITIONS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,  // left_pos, right_pos, operand, modulus, zero fill
	input  logic [1:0]   s_axis_tuser,  // func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // answer, zero fill
	output logic [0:0]   m_axis_tuser   // not_found
);

`include "range_assign_add_kth_powsum_store_defines.svh"

	localparam int AW = $clog2(POSITIONS);
	localparam int CW = AW + 1;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SETUP = 11'b000_0000_0010,
		ST_SWEEP = 11'b000_0000_0100,
		ST_KNEXT = 11'b000_0000_1000,
		ST_PRD   = 11'b000_0001_0000,
		ST_PWT   = 11'b000_0010_0000,
		ST_PRED  = 11'b000_0100_0000,
		ST_PEXP  = 11'b000_1000_0000,
		ST_PMUL  = 11'b001_0000_0000,
		ST_PACC  = 11'b010_0000_0000,
		ST_FIN   = 11'b100_0000_0000
	} state_t;

	state_t           st_q;
	func_t            func_q;
	logic [AW-1:0]    lo_q, hi_q, cur_q;
	logic [VAL_W-1:0] opnd_q;
	logic [MOD_W-1:0] mod_q;
	logic             issued_q;
	logic             vld_s1;
	logic [AW-1:0]    addr_s1;
	logic [CW-1:0]    cnt_q, k_q;
	logic [VAL_W-1:0] pfx_q, mask_q, bsel_q;
	logic [MOD_W-1:0] base_q, res_q, acc_q;
	logic [VAL_W-1:0] e_q;
	logic [VAL_W-1:0] ans_q;
	logic             nf_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] out_ans_q;
	logic             out_nf_q;

	logic             s_acc;
	logic [AW-1:0]    in_a, in_b;
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [VAL_W-1:0] mem_wdata, mem_rdata;
	logic [VAL_W:0]   add_sum;
	logic [CW-1:0]    len;
	logic [VAL_W-1:0] k_eff;
	logic             pfx_bit;
	logic             kmatch;
	logic [MOD_W:0]   acc_sum;
	logic [MOD_W:0]   acc_red;
	logic             fin_load;
	mm_req_t          req0, req1;
	logic             busy0, busy1, done0, done1;
	logic [MOD_W-1:0] r0, r1;

	// Position to memory index, clamping out-of-range positions
	function automatic logic [AW-1:0] pos_index(input logic [POS_W-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		if (w == 32'd0) begin
			return '0;
		end else if (w > 32'(POSITIONS)) begin
			return AW'(POSITIONS - 1);
		end
		return AW'(w - 32'd1);
	endfunction

	assign s_axis_tready = (st_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign in_a          = pos_index(s_axis_tdata[10:0]);
	assign in_b          = pos_index(s_axis_tdata[21:11]);

	// Range length and effective rank
	assign len     = CW'(hi_q - lo_q) + CW'(1);
	assign k_eff   = (opnd_q == '0) ? VAL_W'(1) : opnd_q;
	assign pfx_bit = (k_q > cnt_q);
	assign kmatch  = (((mem_rdata ^ pfx_q) & mask_q) == '0) && ((mem_rdata & bsel_q) == '0);

	// Memory access control
	assign add_sum   = {1'b0, mem_rdata} + {1'b0, opnd_q};
	assign mem_we    = (st_q == ST_SWEEP) && vld_s1 && (func_q == FN_ADD || func_q == FN_ASG);
	assign mem_wdata = (func_q == FN_ASG) ? opnd_q :
	                   (add_sum[VAL_W] ? VAL_MAX : add_sum[VAL_W-1:0]);
	assign mem_re    = ((st_q == ST_SWEEP) && !issued_q) || (st_q == ST_PRD);
	assign mem_raddr = cur_q;

	rakps_mem #(.DEPTH(POSITIONS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr_s1),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Multiplier requests: unit 0 reduces a value or multiplies result by base,
	// unit 1 squares the base.
	always_comb begin
		req0.start = (st_q == ST_PWT) || ((st_q == ST_PEXP) && (e_q != '0));
		req0.a     = (st_q == ST_PWT) ? MOD_W'(1) : res_q;
		req0.b     = (st_q == ST_PWT) ? mem_rdata : {base_q, 32'd0};
		req0.steps = (st_q == ST_PWT) ? 6'd63 : 6'd31;
		req1.start = (st_q == ST_PEXP) && (e_q != '0);
		req1.a     = base_q;
		req1.b     = {base_q, 32'd0};
		req1.steps = 6'd31;
	end

	rakps_modmul u_mm0 (
		.clk(clk), .arst_n(arst_n), .req(req0), .m(mod_q),
		.busy(busy0), .done(done0), .r(r0)
	);

	rakps_modmul u_mm1 (
		.clk(clk), .arst_n(arst_n), .req(req1), .m(mod_q),
		.busy(busy1), .done(done1), .r(r1)
	);

	// Power sum accumulation
	assign acc_sum  = {1'b0, acc_q} + {1'b0, res_q};
	assign acc_red  = (acc_sum >= {1'b0, mod_q}) ? acc_sum - {1'b0, mod_q} : acc_sum;
	assign fin_load = (st_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			issued_q <= 1'b0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= (st_q == ST_SWEEP) && !issued_q;
			case (st_q)
				ST_IDLE: begin
					if (s_acc) begin
						st_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					issued_q <= 1'b0;
					case (func_q)
						FN_KTH:  st_q <= (k_eff > VAL_W'(len)) ? ST_FIN : ST_SWEEP;
						FN_POW:  st_q <= (mod_q < MOD_W'(2)) ? ST_FIN : ST_PRD;
						default: st_q <= ST_SWEEP;
					endcase
				end
				ST_SWEEP: begin
					if (!issued_q && (cur_q == hi_q)) begin
						issued_q <= 1'b1;
					end
					if (issued_q && !vld_s1) begin
						st_q <= (func_q == FN_KTH) ? ST_KNEXT : ST_FIN;
					end
				end
				ST_KNEXT: begin
					issued_q <= 1'b0;
					st_q     <= bsel_q[0] ? ST_FIN : ST_SWEEP;
				end
				ST_PRD:  st_q <= ST_PWT;
				ST_PWT:  st_q <= ST_PRED;
				ST_PRED: begin
					if (done0) begin
						st_q <= ST_PEXP;
					end
				end
				ST_PEXP: st_q <= (e_q == '0) ? ST_PACC : ST_PMUL;
				ST_PMUL: begin
					if (done0 && done1) begin
						st_q <= ST_PEXP;
					end
				end
				ST_PACC: st_q <= (cur_q == hi_q) ? ST_FIN : ST_PRD;
				ST_FIN: begin
					if (fin_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Request payload and working registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			func_q <= func_t'(s_axis_tuser);
			lo_q   <= (in_a < in_b) ? in_a : in_b;
			hi_q   <= (in_a < in_b) ? in_b : in_a;
			opnd_q <= s_axis_tdata[84:22];
			mod_q  <= s_axis_tdata[115:85];
		end
		addr_s1 <= cur_q;
		if (vld_s1 && kmatch) begin
			cnt_q <= cnt_q + CW'(1);
		end
		case (st_q)
			ST_SETUP: begin
				cur_q  <= lo_q;
				cnt_q  <= '0;
				k_q    <= CW'(k_eff);
				pfx_q  <= '0;
				mask_q <= '0;
				bsel_q <= {1'b1, {(VAL_W-1){1'b0}}};
				acc_q  <= '0;
				ans_q  <= '0;
				nf_q   <= (func_q == FN_KTH) && (k_eff > VAL_W'(len));
			end
			ST_SWEEP: begin
				if (!issued_q && (cur_q != hi_q)) begin
					cur_q <= cur_q + AW'(1);
				end
			end
			ST_KNEXT: begin
				cur_q  <= lo_q;
				cnt_q  <= '0;
				mask_q <= mask_q | bsel_q;
				bsel_q <= bsel_q >> 1;
				if (pfx_bit) begin
					pfx_q <= pfx_q | bsel_q;
					k_q   <= k_q - cnt_q;
				end
				ans_q <= pfx_bit ? (pfx_q | bsel_q) : pfx_q;
			end
			ST_PRED: begin
				if (done0) begin
					base_q <= r0;
					res_q  <= MOD_W'(1);
					e_q    <= opnd_q;
				end
			end
			ST_PMUL: begin
				if (done0 && done1) begin
					if (e_q[0]) begin
						res_q <= r0;
					end
					base_q <= r1;
					e_q    <= e_q >> 1;
				end
			end
			ST_PACC: begin
				acc_q <= acc_red[MOD_W-1:0];
				ans_q <= VAL_W'(acc_red[MOD_W-1:0]);
				if (cur_q != hi_q) begin
					cur_q <= cur_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_ans_q <= nf_q ? '0 : ans_q;
			out_nf_q  <= nf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_ans_q};
	assign m_axis_tuser  = out_nf_q;

	// Checks
	`RAKPS_ASSERT_SAME(a_we_sweep, mem_we, st_q == ST_SWEEP)
	`RAKPS_ASSERT_SAME(a_nf_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
	`RAKPS_ASSERT_SAME(a_mm_idle, req0.start || req1.start, !busy0 && !busy1)
	`RAKPS_ASSERT_NEXT(a_acc_setup, s_acc, st_q == ST_SETUP)

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the range value store (add, assign, kth, power sum).
// Depends on rakps_pkg and range_assign_add_kth_powsum_store from the rtl folder.
// A scoreboard class predicts each answer; tasks send, an always block receives.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rakps_pkg::*;

	localparam int NPOS = 1024;

	typedef struct {
		logic [VAL_W-1:0] answer;
		logic             not_found;
	} outcome_t;

	// Predicts every answer from its own copy of the stored values.
	class range_scoreboard;
		logic [VAL_W-1:0] cells [NPOS];
		outcome_t         awaited [$];
		int               mismatches;
		int               checked;

		function int clamp_pos(logic [POS_W-1:0] p);
			if (p < 1) return 1;
			if (p > NPOS) return NPOS;
			return int'(p);
		endfunction

		// Note an accepted request and queue the answer it should produce.
		function void note_request(func_t f, logic [POS_W-1:0] lp, logic [POS_W-1:0] rp,
				logic [VAL_W-1:0] opnd, logic [MOD_W-1:0] modv);
			int lo, hi, t;
			longint unsigned len, k, m, acc, base, res, e;
			logic [VAL_W-1:0] ranked [$];
			outcome_t o;
			lo = clamp_pos(lp) - 1;
			hi = clamp_pos(rp) - 1;
			if (lo > hi) begin
				t = lo;
				lo = hi;
				hi = t;
			end
			o.answer = '0;
			o.not_found = 1'b0;
			case (f)
				FN_ADD: begin
					for (int i = lo; i <= hi; i++)
						cells[i] = (cells[i] > VAL_MAX - opnd) ? VAL_MAX : cells[i] + opnd;
				end
				FN_ASG: begin
					for (int i = lo; i <= hi; i++)
						cells[i] = opnd;
				end
				FN_KTH: begin
					len = 64'(hi - lo + 1);
					k = (opnd == 0) ? 64'd1 : 64'(opnd);
					if (k > len) begin
						o.not_found = 1'b1;
					end else begin
						for (int i = lo; i <= hi; i++)
							ranked.insert(ranked.size(), cells[i]);
						ranked.sort();
						o.answer = ranked[k-1];
					end
				end
				default: begin
					m = 64'(modv);
					if (m != 0) begin
						acc = 64'd0;
						for (int i = lo; i <= hi; i++) begin
							base = 64'(cells[i]) % m;
							res = 64'd1 % m;
							e = 64'(opnd);
							while (e != 0) begin
								if (e[0])
									res = (res * base) % m;
								base = (base * base) % m;
								e = e >> 1;
							end
							acc = (acc + res) % m;
						end
						o.answer = VAL_W'(acc);
					end
				end
			endcase
			awaited.insert(awaited.size(), o);
		endfunction

		// Compare one output word with the oldest queued answer.
		function void check_result(logic [VAL_W-1:0] ans, logic nf);
			outcome_t o;
			checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result answer=%0d not_found=%0b", ans, nf);
				return;
			end
			o = awaited.pop_front();
			if (ans !== o.answer || nf !== o.not_found) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d expected answer=%0d not_found=%0b, got %0d %0b",
						checked, o.answer, o.not_found, ans, nf);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata;  // left_pos, right_pos, operand, modulus, zero fill
	logic [1:0]   s_axis_tuser;  // func
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;  // answer, zero fill
	logic [0:0]   m_axis_tuser;  // not_found

	range_scoreboard sb;
	bit calm;
	int sent_by_func [4];

	range_assign_add_kth_powsum_store #(.POSITIONS(NPOS)) dut (.*);

	// Clock with a 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Safety limit in case the block hangs.
	initial begin
		#80_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Mostly short gaps, now and then a long one, none while calm.
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	// Receiver side: random stalls on tready.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left = 0;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// Check every output word taken by the receiver.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[VAL_W-1:0], m_axis_tuser[0]);
	end

	// Send one request word and note it once it is accepted.
	task automatic send_req(func_t f, logic [POS_W-1:0] lp, logic [POS_W-1:0] rp,
			logic [VAL_W-1:0] opnd, logic [MOD_W-1:0] modv);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, modv, opnd, rp, lp};
		s_axis_tuser <= f;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(f, lp, rp, opnd, modv);
		sent_by_func[f]++;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] rand_val();
		return VAL_W'({$urandom, $urandom});
	endfunction

	// One random request; ranges are kept short where the block is slow.
	task automatic random_req();
		func_t f;
		int lp, w, bl, sel;
		logic [VAL_W-1:0] opnd;
		logic [MOD_W-1:0] modv;
		logic [POS_W-1:0] a, b;
		sel = $urandom_range(0, 99);
		f = (sel < 25) ? FN_ADD : (sel < 50) ? FN_ASG : (sel < 75) ? FN_KTH : FN_POW;
		case (f)
			FN_KTH: w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
				: $urandom_range(0, 63);
			FN_POW: w = $urandom_range(0, 7);
			default: w = $urandom_range(0, 1023);
		endcase
		lp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 1030);
		a = POS_W'(lp);
		b = (lp + w > 2047) ? 11'd2047 : POS_W'(lp + w);
		if ($urandom_range(0, 1)) begin
			a = b;
			b = POS_W'(lp);
		end
		sel = $urandom_range(0, 3);
		case (f)
			FN_ADD: opnd = (sel == 0) ? VAL_MAX - VAL_W'($urandom_range(0, 1000))
				: (sel == 1) ? rand_val() : VAL_W'($urandom_range(0, 1000));
			FN_ASG: opnd = (sel == 0) ? rand_val() : VAL_W'($urandom_range(0, 50));
			FN_KTH: opnd = (sel == 0) ? rand_val() : VAL_W'($urandom_range(0, w + 3));
			default: begin
				bl = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(9, 63);
				opnd = (bl == 0) ? '0 : rand_val() >> (63 - bl);
			end
		endcase
		sel = $urandom_range(0, 9);
		modv = (sel == 0) ? MOD_W'($urandom_range(0, 1))
			: (sel < 4) ? MOD_W'($urandom_range(2, 100)) : MOD_W'($urandom);
		send_req(f, a, b, opnd, modv);
	endtask

	initial begin
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FN_ADD;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: every position written first, then the corner cases.
		send_req(FN_ASG, 11'd1, 11'd1024, 63'd7, 31'd0);
		send_req(FN_KTH, 11'd1024, 11'd1, 63'd1024, 31'd0);
		send_req(FN_ASG, 11'd0, 11'd4, VAL_MAX, 31'd5);
		send_req(FN_ADD, 11'd4, 11'd1, 63'd1, 31'd0);
		send_req(FN_ADD, 11'd2047, 11'd1000, 63'd0, 31'h7FFFFFFF);
		send_req(FN_ASG, 11'd20, 11'd10, 63'd3, 31'd0);
		send_req(FN_ADD, 11'd15, 11'd30, 63'd11, 31'd0);
		send_req(FN_KTH, 11'd1, 11'd30, 63'd0, 31'd0);
		send_req(FN_KTH, 11'd1, 11'd30, 63'd30, 31'd0);
		send_req(FN_KTH, 11'd1, 11'd30, 63'd31, 31'd0);
		send_req(FN_KTH, 11'd5, 11'd5, VAL_MAX, 31'd0);
		send_req(FN_POW, 11'd1, 11'd6, 63'd5, 31'd0);
		send_req(FN_POW, 11'd1, 11'd6, 63'd5, 31'd1);
		send_req(FN_POW, 11'd1, 11'd6, 63'd0, 31'd97);
		send_req(FN_POW, 11'd1, 11'd3, VAL_MAX, 31'h7FFFFFFF);
		send_req(FN_POW, 11'd2047, 11'd2047, 63'd3, 31'd1000);
		send_req(FN_KTH, 11'd0, 11'd2047, 63'd1, 31'd0);
		send_req(FN_ASG, 11'd2047, 11'd0, 63'd0, 31'd0);
		send_req(FN_POW, 11'd8, 11'd1, 63'd9, 31'd13);
		// Hold the sender until every answer is back.
		drain();

		// Random part, with a calm stretch in the middle.
		for (int n = 0; n < 140; n++) begin
			calm = (n >= 60 && n < 80);
			random_req();
			if (n == 100) drain();
		end
		calm = 1'b0;
		drain();
		repeat (50) @(posedge clk);

		$display("Covered %0d add, %0d assign, %0d kth and %0d power sum requests,",
			sent_by_func[FN_ADD], sent_by_func[FN_ASG], sent_by_func[FN_KTH],
			sent_by_func[FN_POW]);
		$display("with clamped, reversed and saturating cases and random stalls on both sides.");
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
